[hdl/tsls_pkg.sv]
// Shared constants, types and helper functions of the two-sensor line steering block.
`default_nettype none
package tsls_pkg;

  localparam int RING_DEPTH    = 10;
  localparam int AVERAGE_COUNT = 5;

  localparam int SAMPLE_W = 8;
  localparam int IDX_W    = $clog2(RING_DEPTH);
  localparam int CNT_W    = (AVERAGE_COUNT > 1) ? $clog2(AVERAGE_COUNT) : 1;

  // Sum of AVERAGE_COUNT samples, then divide by reciprocal multiply.
  // With SHIFT = SUM_W + clog2(N) and RECIP = ceil(2^SHIFT / N) the
  // quotient is exact for every sum below 2^SUM_W.
  localparam int SUM_W     = $clog2(AVERAGE_COUNT * 255 + 1);
  localparam int DIV_SHIFT = SUM_W + $clog2(AVERAGE_COUNT);
  localparam int DIV_RECIP = ((2 ** DIV_SHIFT) + AVERAGE_COUNT - 1) / AVERAGE_COUNT;
  localparam int RECIP_W   = DIV_SHIFT + 1;
  localparam int PROD_W    = SUM_W + RECIP_W;

  // Bucket = avg / 40, exact for 8-bit values as (avg * 205) >> 13.
  localparam int BUCKET_RECIP = 205;
  localparam int BUCKET_SHIFT = 13;
  localparam int BUCKET_PW    = 16;
  localparam int BUCKET_W     = 3;

  localparam int CFG_IDX_W = 3;

  typedef enum logic {
    CMD_SAMPLE   = 1'b0,
    CMD_EVALUATE = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 3'd0,
    CFG_LEFT      = 3'd1,
    CFG_RIGHT     = 3'd2,
    CFG_STRAIGHT  = 3'd3,
    CFG_IDLE      = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DIVIDE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic write;
    logic load;
    logic accum;
    logic divide;
  } lane_ctrl_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] threshold;
    logic [SAMPLE_W-1:0] left_pattern;
    logic [SAMPLE_W-1:0] right_pattern;
    logic [SAMPLE_W-1:0] straight_pattern;
    logic [SAMPLE_W-1:0] idle_pattern;
  } cfg_t;

  function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] nxt;
    if (idx == IDX_W'(RING_DEPTH - 1)) begin
      nxt = '0;
    end else begin
      nxt = idx + IDX_W'(1);
    end
    return nxt;
  endfunction

  function automatic logic [BUCKET_W-1:0] bucket(input logic [SAMPLE_W-1:0] avg);
    logic [BUCKET_PW-1:0] prod;
    prod = BUCKET_PW'(avg) * BUCKET_PW'(BUCKET_RECIP);
    return prod[BUCKET_SHIFT +: BUCKET_W];
  endfunction

endpackage
`default_nettype wire

[hdl/two_sensor_line_steering.sv]
// Top level of the two-sensor line steering block: control sequencer, config and lanes.
`default_nettype none
// A sample transaction (cmd 0) stores one reading per sensor into a 10-deep ring
// and advances the write index in the cycle it is accepted; it gives no result.
// An evaluate transaction (cmd 1) gives exactly one result. When the switch
// value is zero or the block is already running, two lanes (one per sensor)
// walk five ring entries from the write index, one entry per cycle, then
// divide their sums by five with a reciprocal multiply; the merge stage picks
// the drive pattern from the two averages and sets the running flag.
// Otherwise the result carries the idle pattern and zero averages.
// Sequence: a sample leaves the sequencer idle; an evaluation passes the walk
// and divide states (skipped when disabled) and the emit state, where the
// result may wait for a free output register. Input is taken only while the
// sequencer is idle; the output register lets a finished result wait for
// out_ready while the next transaction is accepted. Configuration is written
// through cfg_wr_en/cfg_index/cfg_wdata; write only while the block is idle.
// The rings, write index, last turn and running flag clear on reset.
module two_sensor_line_steering (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              in_cmd,
  input  wire logic [tsls_pkg::SAMPLE_W-1:0]     in_sensor_one_sample,
  input  wire logic [tsls_pkg::SAMPLE_W-1:0]     in_sensor_two_sample,
  input  wire logic [tsls_pkg::SAMPLE_W-1:0]     in_switch_value,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic      [tsls_pkg::SAMPLE_W-1:0]     out_drive_pattern,
  output logic      [tsls_pkg::SAMPLE_W-1:0]     out_average_one,
  output logic      [tsls_pkg::SAMPLE_W-1:0]     out_average_two,
  input  wire logic                              cfg_wr_en,
  input  wire logic [tsls_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [tsls_pkg::SAMPLE_W-1:0]     cfg_wdata
);

  tsls_pkg::state_t            state_r;
  tsls_pkg::state_t            state_nxt;
  tsls_pkg::cfg_t              cfg_r;
  tsls_pkg::lane_ctrl_t        lane_ctrl;
  logic [tsls_pkg::IDX_W-1:0]  wr_idx_r;
  logic [tsls_pkg::CNT_W-1:0]  cnt_r;
  logic                        enable_r;
  logic                        accept;
  logic                        is_eval;
  logic                        eval_on;
  logic                        emit;
  logic                        running;
  logic                        walk_last;
  logic [tsls_pkg::SAMPLE_W-1:0] avg_one;
  logic [tsls_pkg::SAMPLE_W-1:0] avg_two;

  assign in_ready  = (state_r == tsls_pkg::ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign is_eval   = (in_cmd == tsls_pkg::CMD_EVALUATE);
  // Evaluate when the switch reads zero or an earlier enabled evaluation already ran.
  assign eval_on   = (in_switch_value == '0) || running;
  assign walk_last = (cnt_r == tsls_pkg::CNT_W'(tsls_pkg::AVERAGE_COUNT - 1));

  // Configuration registers: plain indexed write, no read-back.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold        <= 8'd200;
      cfg_r.left_pattern     <= 8'h0D;
      cfg_r.right_pattern    <= 8'h07;
      cfg_r.straight_pattern <= 8'h05;
      cfg_r.idle_pattern     <= 8'hFF;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        tsls_pkg::CFG_THRESHOLD: cfg_r.threshold        <= cfg_wdata;
        tsls_pkg::CFG_LEFT:      cfg_r.left_pattern     <= cfg_wdata;
        tsls_pkg::CFG_RIGHT:     cfg_r.right_pattern    <= cfg_wdata;
        tsls_pkg::CFG_STRAIGHT:  cfg_r.straight_pattern <= cfg_wdata;
        tsls_pkg::CFG_IDLE:      cfg_r.idle_pattern     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sequencer: idle -> walk (AVERAGE_COUNT entries) -> divide -> emit, or idle -> emit when disabled.
  always_comb begin
    state_nxt        = state_r;
    lane_ctrl.write  = 1'b0;
    lane_ctrl.load   = 1'b0;
    lane_ctrl.accum  = 1'b0;
    lane_ctrl.divide = 1'b0;
    emit             = 1'b0;
    unique case (state_r)
      tsls_pkg::ST_IDLE: begin
        if (accept) begin
          if (!is_eval) begin
            lane_ctrl.write = 1'b1;
          end else if (eval_on) begin
            lane_ctrl.load = 1'b1;
            state_nxt      = tsls_pkg::ST_WALK;
          end else begin
            // Skip the walk: the result is the idle pattern.
            state_nxt = tsls_pkg::ST_EMIT;
          end
        end
      end
      tsls_pkg::ST_WALK: begin
        lane_ctrl.accum = 1'b1;
        if (walk_last) begin
          state_nxt = tsls_pkg::ST_DIVIDE;
        end
      end
      tsls_pkg::ST_DIVIDE: begin
        lane_ctrl.divide = 1'b1;
        state_nxt        = tsls_pkg::ST_EMIT;
      end
      tsls_pkg::ST_EMIT: begin
        // Hold until the output register is free.
        if (!out_valid || out_ready) begin
          emit      = 1'b1;
          state_nxt = tsls_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tsls_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= tsls_pkg::ST_IDLE;
      wr_idx_r <= '0;
      cnt_r    <= '0;
      enable_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (lane_ctrl.write) begin
        wr_idx_r <= tsls_pkg::idx_next(wr_idx_r);
      end
      if (accept && is_eval) begin
        enable_r <= eval_on;
      end
      if (lane_ctrl.load) begin
        cnt_r <= '0;
      end else if (lane_ctrl.accum) begin
        cnt_r <= cnt_r + tsls_pkg::CNT_W'(1);
      end
    end
  end

  tsls_lane u_lane_one (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (lane_ctrl),
    .wr_idx (wr_idx_r),
    .sample (in_sensor_one_sample),
    .avg    (avg_one)
  );

  tsls_lane u_lane_two (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (lane_ctrl),
    .wr_idx (wr_idx_r),
    .sample (in_sensor_two_sample),
    .avg    (avg_two)
  );

  tsls_merge u_merge (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .emit              (emit),
    .enable            (enable_r),
    .avg_one           (avg_one),
    .avg_two           (avg_two),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_drive_pattern (out_drive_pattern),
    .out_average_one   (out_average_one),
    .out_average_two   (out_average_two),
    .running           (running)
  );

`ifndef ASSERT_OFF
  a_wr_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_idx_r <= tsls_pkg::IDX_W'(tsls_pkg::RING_DEPTH - 1))
    else $error("write index beyond ring depth");

  a_sample_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !is_eval) |=> !$rose(out_valid))
    else $error("sample transaction produced a result");

  a_emit_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tsls_pkg::ST_EMIT && !out_valid) |=> out_valid)
    else $error("free output register not loaded from emit");

  a_running_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !$fell(running))
    else $error("running flag cleared outside reset");
`endif

endmodule
`default_nettype wire

[hdl/tsls_lane.sv]
// One sensor lane: sample ring, five-entry sum walk and divide by the count.
`default_nettype none
module tsls_lane (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire tsls_pkg::lane_ctrl_t                ctrl,
  input  wire logic [tsls_pkg::IDX_W-1:0]          wr_idx,
  input  wire logic [tsls_pkg::SAMPLE_W-1:0]       sample,
  output logic      [tsls_pkg::SAMPLE_W-1:0]       avg
);

  logic [tsls_pkg::SAMPLE_W-1:0] ring_r [tsls_pkg::RING_DEPTH];
  logic [tsls_pkg::IDX_W-1:0]    pos_r;
  logic [tsls_pkg::SUM_W-1:0]    sum_r;
  logic [tsls_pkg::SAMPLE_W-1:0] avg_r;
  logic [tsls_pkg::PROD_W-1:0]   prod;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < tsls_pkg::RING_DEPTH; i++) begin
        ring_r[i] <= '0;
      end
    end else if (ctrl.write) begin
      ring_r[wr_idx] <= sample;
    end
  end

  // Walk from the write index, one entry per cycle.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      pos_r <= wr_idx;
      sum_r <= '0;
    end else if (ctrl.accum) begin
      pos_r <= tsls_pkg::idx_next(pos_r);
      sum_r <= sum_r + tsls_pkg::SUM_W'(ring_r[pos_r]);
    end
  end

  assign prod = tsls_pkg::PROD_W'(sum_r) * tsls_pkg::PROD_W'(tsls_pkg::DIV_RECIP);

  always_ff @(posedge clk) begin
    if (ctrl.divide) begin
      avg_r <= prod[tsls_pkg::DIV_SHIFT +: tsls_pkg::SAMPLE_W];
    end
  end

  assign avg = avg_r;

endmodule
`default_nettype wire

[hdl/tsls_merge.sv]
// Merge stage: combines both lane averages into a drive pattern and holds the result.
`default_nettype none
module tsls_merge (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire tsls_pkg::cfg_t                cfg,
  input  wire logic                          emit,
  input  wire logic                          enable,
  input  wire logic [tsls_pkg::SAMPLE_W-1:0] avg_one,
  input  wire logic [tsls_pkg::SAMPLE_W-1:0] avg_two,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic      [tsls_pkg::SAMPLE_W-1:0] out_drive_pattern,
  output logic      [tsls_pkg::SAMPLE_W-1:0] out_average_one,
  output logic      [tsls_pkg::SAMPLE_W-1:0] out_average_two,
  output logic                               running
);

  logic                          valid_r;
  logic                          running_r;
  logic [tsls_pkg::SAMPLE_W-1:0] last_turn_r;
  logic [tsls_pkg::SAMPLE_W-1:0] last_turn_nxt;
  logic [tsls_pkg::SAMPLE_W-1:0] pattern_r;
  logic [tsls_pkg::SAMPLE_W-1:0] pattern_nxt;
  logic [tsls_pkg::SAMPLE_W-1:0] avg_one_r;
  logic [tsls_pkg::SAMPLE_W-1:0] avg_two_r;
  logic [tsls_pkg::BUCKET_W-1:0] bucket_one;
  logic [tsls_pkg::BUCKET_W-1:0] bucket_two;

  assign bucket_one = tsls_pkg::bucket(avg_one);
  assign bucket_two = tsls_pkg::bucket(avg_two);

  always_comb begin
    last_turn_nxt = last_turn_r;
    if (!enable) begin
      pattern_nxt = cfg.idle_pattern;
    end else if (avg_one > cfg.threshold && avg_two > cfg.threshold) begin
      pattern_nxt = last_turn_r;
    end else if (bucket_one > bucket_two) begin
      pattern_nxt   = cfg.left_pattern;
      last_turn_nxt = cfg.left_pattern;
    end else if (bucket_one < bucket_two) begin
      pattern_nxt   = cfg.right_pattern;
      last_turn_nxt = cfg.right_pattern;
    end else begin
      pattern_nxt = cfg.straight_pattern;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= 1'b0;
      running_r   <= 1'b0;
      last_turn_r <= '0;
    end else if (emit) begin
      valid_r <= 1'b1;
      if (enable) begin
        running_r   <= 1'b1;
        last_turn_r <= last_turn_nxt;
      end
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pattern_r <= pattern_nxt;
      avg_one_r <= enable ? avg_one : '0;
      avg_two_r <= enable ? avg_two : '0;
    end
  end

  assign out_valid         = valid_r;
  assign out_drive_pattern = pattern_r;
  assign out_average_one   = avg_one_r;
  assign out_average_two   = avg_two_r;
  assign running           = running_r;

endmodule
`default_nettype wire
